// ===== hdl/u16550_pkg.sv =====
// Shared types and constants for the 16550A-style UART register model.
// No dependencies; u16550_fifo and the core import this package.
package u16550_pkg;

    parameter int unsigned DEFAULT_FIFO_DEPTH = 16;

    // Transaction commands
    localparam logic [1:0] CMD_HOST_READ  = 2'd0;
    localparam logic [1:0] CMD_HOST_WRITE = 2'd1;
    localparam logic [1:0] CMD_LINE_RX    = 2'd2;
    localparam logic [1:0] CMD_LINE_TX    = 2'd3;

    // Register offsets from the port base
    localparam logic [2:0] OFF_DATA = 3'd0;
    localparam logic [2:0] OFF_IER  = 3'd1;
    localparam logic [2:0] OFF_IIR  = 3'd2;
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;
    localparam logic [2:0] OFF_MSR  = 3'd6;
    localparam logic [2:0] OFF_SCR  = 3'd7;

    localparam logic [7:0] MCR_RESET    = 8'h08;
    localparam logic [7:0] MSR_CONST    = 8'hB0;
    localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
    localparam logic [7:0] IIR_RX_DATA  = 8'h04;
    localparam logic [7:0] IIR_THR_EMPTY = 8'h02;
    localparam logic [7:0] IIR_NONE     = 8'h01;
    localparam logic [3:0] IER_MASK     = 4'hF;

    localparam int unsigned LCR_DLAB_BIT   = 7;
    localparam int unsigned MCR_LOOP_BIT   = 4;
    localparam int unsigned FCR_CLR_RX_BIT = 1;
    localparam int unsigned FCR_CLR_TX_BIT = 2;
    localparam int unsigned IER_RX_BIT     = 0;
    localparam int unsigned IER_THR_BIT    = 1;

    // FIFO operation request from the register logic
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_ctl;

endpackage

// ===== hdl/u16550_if.sv =====
// Valid/ready channel interfaces for the UART register model.
// Depends on nothing; one interface for commands, one for responses.
interface u16550_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] reg_offset;
    logic [7:0] data_byte;
    logic       burst_start;

    modport source (output valid, command, reg_offset, data_byte, burst_start, input ready);
    modport sink   (input valid, command, reg_offset, data_byte, burst_start, output ready);
endinterface

interface u16550_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       status;
    logic       irq_level;

    modport source (output valid, read_byte, status, irq_level, input ready);
    modport sink   (input valid, read_byte, status, irq_level, output ready);
endinterface

// ===== hdl/u16550_fifo.sv =====
// Byte FIFO with head pointer, fill count and registered read data.
// Depends on u16550_pkg (t_fifo_ctl, DEFAULT_FIFO_DEPTH).
module u16550_fifo import u16550_pkg::*; #(
    parameter int unsigned DEPTH = DEFAULT_FIFO_DEPTH,
    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_fifo_ctl     i_ctl,
    input  logic [7:0]    i_data,
    output logic [CW-1:0] o_count,
    output logic [7:0]    o_rd_data
);
    localparam int unsigned SW = CW + 1;

    logic [7:0]    r_mem [DEPTH];
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [7:0]    r_rd_data;
    logic [IW-1:0] n_head;
    logic [SW-1:0] w_sum;
    logic [IW-1:0] w_waddr;

    // Tail = head + count, wrapped once (sum stays below twice the depth)
    assign w_sum   = SW'(r_head) + SW'(r_count);
    assign w_waddr = (w_sum >= SW'(DEPTH)) ? IW'(w_sum - SW'(DEPTH)) : IW'(w_sum);
    assign n_head  = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.push) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctl.pop) begin
            r_head  <= n_head;
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_waddr] <= i_data;
        end
        if (i_ctl.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_count   = r_count;
    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/uart_16550a_register_model_core.sv =====
// UART 16550A register model: one transaction per clock (host read or write,
// line receive byte, or transmit pull); the response appears in the cycle after
// acceptance and is held in an output register, so a new transaction is taken
// every cycle while the response channel keeps up. FIFO read data comes from the
// registered read port of the RX and TX FIFO memories (FIFO_DEPTH bytes
// each). Depends on u16550_pkg, u16550_if and u16550_fifo.
module uart_16550a_register_model_core import u16550_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u16550_cmd_if.sink    i_cmd,
    u16550_rsp_if.source  o_rsp
);
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] HALF_CNT = CW'(FIFO_DEPTH / 2);

    // Response data source
    localparam logic [1:0] SEL_REG = 2'd0;
    localparam logic [1:0] SEL_RX  = 2'd1;
    localparam logic [1:0] SEL_TX  = 2'd2;

    logic [7:0] r_lcr, n_lcr;
    logic [3:0] r_ier, n_ier;
    logic [7:0] r_mcr, n_mcr;
    logic [7:0] r_scr, n_scr;
    logic [7:0] r_dll, n_dll;
    logic [7:0] r_dlm, n_dlm;
    logic       r_dr, n_dr;
    logic       r_thre, n_thre;
    logic       r_temt, n_temt;
    logic       r_burst, n_burst;
    logic       r_out_valid, n_out_valid;
    logic       r_status, n_status;
    logic       r_irq, n_irq;
    logic [7:0] r_reg_rd, n_reg_rd;
    logic [1:0] r_rd_sel, n_rd_sel;

    t_fifo_ctl     w_rx_ctl, w_tx_ctl;
    logic [7:0]    w_rx_wdata;
    logic [CW-1:0] w_rx_count, w_tx_count, w_tx_after;
    logic [7:0]    w_rx_rd, w_tx_rd, w_iir;
    logic          w_accept, w_dlab, w_loop, w_rx_full, w_tx_full;

    u16550_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_rx_ctl),
        .i_data    (w_rx_wdata),
        .o_count   (w_rx_count),
        .o_rd_data (w_rx_rd)
    );

    u16550_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_tx_ctl),
        .i_data    (i_cmd.data_byte),
        .o_count   (w_tx_count),
        .o_rd_data (w_tx_rd)
    );

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_dlab      = r_lcr[LCR_DLAB_BIT];
    assign w_loop      = r_mcr[MCR_LOOP_BIT];
    assign w_rx_full   = (w_rx_count == FULL_CNT);
    assign w_tx_full   = (w_tx_count == FULL_CNT);
    assign w_tx_after  = w_tx_full ? w_tx_count : w_tx_count + 1'b1;
    assign w_rx_wdata  = i_cmd.data_byte;

    // Receive data outranks transmitter empty
    always_comb begin
        if (r_ier[IER_RX_BIT] && r_dr) begin
            w_iir = IIR_FIFO_ON | IIR_RX_DATA;
        end else if (r_ier[IER_THR_BIT] && r_temt) begin
            w_iir = IIR_FIFO_ON | IIR_THR_EMPTY;
        end else begin
            w_iir = IIR_FIFO_ON | IIR_NONE;
        end
    end

    always_comb begin
        n_lcr    = r_lcr;
        n_ier    = r_ier;
        n_mcr    = r_mcr;
        n_scr    = r_scr;
        n_dll    = r_dll;
        n_dlm    = r_dlm;
        n_dr     = r_dr;
        n_thre   = r_thre;
        n_temt   = r_temt;
        n_burst  = r_burst;
        n_status = r_status;
        n_reg_rd = r_reg_rd;
        n_rd_sel = r_rd_sel;
        w_rx_ctl = '0;
        w_tx_ctl = '0;

        if (w_accept) begin
            n_status = 1'b0;
            n_reg_rd = 8'h00;
            n_rd_sel = SEL_REG;
            case (i_cmd.command)
                CMD_HOST_READ: begin
                    case (i_cmd.reg_offset)
                        OFF_DATA: begin
                            if (w_dlab) begin
                                n_reg_rd = r_dll;
                            end else if (w_rx_count == '0) begin
                                n_status = 1'b1;
                            end else begin
                                w_rx_ctl.pop = 1'b1;
                                n_rd_sel     = SEL_RX;
                                if (w_rx_count == CW'(1)) begin
                                    n_dr = 1'b0;
                                end
                            end
                        end
                        OFF_IER: n_reg_rd = w_dlab ? r_dlm : {4'h0, r_ier};
                        OFF_IIR: n_reg_rd = w_iir;
                        OFF_LCR: n_reg_rd = r_lcr;
                        OFF_MCR: n_reg_rd = r_mcr;
                        OFF_LSR: n_reg_rd = {1'b0, r_temt, r_thre, 4'h0, r_dr};
                        OFF_MSR: n_reg_rd = MSR_CONST;
                        default: n_reg_rd = r_scr;
                    endcase
                end
                CMD_HOST_WRITE: begin
                    case (i_cmd.reg_offset)
                        OFF_DATA: begin
                            if (w_dlab) begin
                                n_dll = i_cmd.data_byte;
                            end else if (w_loop) begin
                                // Loopback: THR byte lands in the receive FIFO
                                if (w_rx_full) begin
                                    n_status = 1'b1;
                                end else begin
                                    w_rx_ctl.push = 1'b1;
                                    n_dr          = 1'b1;
                                end
                            end else begin
                                if (w_tx_full) begin
                                    n_status = 1'b1;
                                end else begin
                                    w_tx_ctl.push = 1'b1;
                                    n_temt        = 1'b0;
                                end
                                if (w_tx_after >= HALF_CNT) begin
                                    n_thre = 1'b0;
                                end
                            end
                        end
                        OFF_IER: begin
                            if (w_dlab) begin
                                n_dlm = i_cmd.data_byte;
                            end else begin
                                n_ier = i_cmd.data_byte[3:0] & IER_MASK;
                            end
                        end
                        OFF_IIR: begin
                            if (i_cmd.data_byte[FCR_CLR_RX_BIT]) begin
                                w_rx_ctl.clear = 1'b1;
                                n_dr           = 1'b0;
                                n_burst        = 1'b0;
                            end
                            if (i_cmd.data_byte[FCR_CLR_TX_BIT]) begin
                                w_tx_ctl.clear = 1'b1;
                                n_temt         = 1'b1;
                                n_thre         = 1'b1;
                            end
                        end
                        OFF_LCR: n_lcr = i_cmd.data_byte;
                        OFF_MCR: n_mcr = i_cmd.data_byte;
                        OFF_SCR: n_scr = i_cmd.data_byte;
                        default: ;
                    endcase
                end
                CMD_LINE_RX: begin
                    if (i_cmd.burst_start &&
                        (w_loop || r_dr || (w_rx_count != '0))) begin
                        n_burst  = 1'b0;
                        n_status = 1'b1;
                    end else if (!i_cmd.burst_start && !r_burst) begin
                        n_status = 1'b1;
                    end else if (w_rx_full) begin
                        // Drop the byte and close the burst
                        n_burst  = 1'b0;
                        n_status = 1'b1;
                    end else begin
                        n_burst       = 1'b1;
                        w_rx_ctl.push = 1'b1;
                        n_dr          = 1'b1;
                    end
                end
                default: begin
                    if (w_tx_count == '0) begin
                        n_status = 1'b1;
                    end else begin
                        w_tx_ctl.pop = 1'b1;
                        n_rd_sel     = SEL_TX;
                        if (w_tx_count == CW'(1)) begin
                            n_temt = 1'b1;
                            n_thre = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign n_irq = (n_ier[IER_RX_BIT] && n_dr) || (n_ier[IER_THR_BIT] && n_temt);
    assign n_out_valid = w_accept || (r_out_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcr       <= 8'h00;
            r_ier       <= 4'h0;
            r_mcr       <= MCR_RESET;
            r_scr       <= 8'h00;
            r_dll       <= 8'h00;
            r_dlm       <= 8'h00;
            r_dr        <= 1'b0;
            r_thre      <= 1'b1;
            r_temt      <= 1'b1;
            r_burst     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lcr       <= n_lcr;
            r_ier       <= n_ier;
            r_mcr       <= n_mcr;
            r_scr       <= n_scr;
            r_dll       <= n_dll;
            r_dlm       <= n_dlm;
            r_dr        <= n_dr;
            r_thre      <= n_thre;
            r_temt      <= n_temt;
            r_burst     <= n_burst;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload, updated only on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_irq    <= n_irq;
            r_reg_rd <= n_reg_rd;
            r_rd_sel <= n_rd_sel;
        end
    end

    always_comb begin
        case (r_rd_sel)
            SEL_RX:  o_rsp.read_byte = w_rx_rd;
            SEL_TX:  o_rsp.read_byte = w_tx_rd;
            default: o_rsp.read_byte = r_reg_rd;
        endcase
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.irq_level = r_irq;

    a_dr_matches_rx_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dr == (w_rx_count != '0))
        else $error("LSR DR out of step with RX FIFO fill");

    a_temt_matches_tx_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_temt == (w_tx_count == '0))
        else $error("LSR TEMT out of step with TX FIFO fill");

    a_thre_low_at_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tx_count >= HALF_CNT) |-> !r_thre)
        else $error("THRE set with TX FIFO at or above half full");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !i_cmd.ready)
        else $error("transaction accepted while response is stalled");

    a_one_fifo_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_rx_ctl.push, w_rx_ctl.pop, w_tx_ctl.push, w_tx_ctl.pop}) <= 1)
        else $error("more than one FIFO push or pop in one transaction");

endmodule

// ===== tb/sv/uart_16550a_register_model_core_tb.sv =====
// Self-checking testbench for the 16550A-style UART register model core.
// Needs u16550_pkg, u16550_cmd_if/u16550_rsp_if and the core; drives commands,
// predicts each response in-line or takes it from the directed row, and checks them in order against the DUT.
module uart_16550a_register_model_core_tb import u16550_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEFAULT_FIFO_DEPTH;
    localparam int RANDOM_ITEMS = 1100;
    localparam int LSR_DR_BIT   = 0;
    localparam int LSR_THRE_BIT = 5;
    localparam int LSR_TEMT_BIT = 6;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       status;
        logic       irq_level;
    } uart_rsp_t;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] reg_offset;
        logic [7:0] data_byte;
        logic       burst_start;
        logic       typed;
        logic [7:0] want_byte;
        logic       want_status;
        logic       want_irq;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    u16550_cmd_if cmd_ch ();
    u16550_rsp_if rsp_ch ();

    uart_16550a_register_model_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted UART register state
    // ------------------------------------------------------------------
    logic [7:0]  u_lcr, u_mcr, u_fcr, u_scr, u_dll, u_dlm, u_lsr;
    logic [3:0]  u_ier;
    logic [7:0]  rx_mem [DEPTH];
    logic [7:0]  tx_mem [DEPTH];
    int unsigned rx_level, tx_level, rx_ptr, tx_ptr;
    bit          rx_burst;

    uart_rsp_t   pending_responses [$];
    stim_row_t   cur_row;
    int          mismatches = 0;
    int          responses_seen = 0;
    int          items_sent = 0;
    int          src_gap_max = 3;
    int          snk_gap_max = 3;
    int          rsp_hold_cycles = 0;

    function automatic logic [7:0] iir_code();
        if (u_ier[IER_RX_BIT] && u_lsr[LSR_DR_BIT])
            return IIR_RX_DATA;
        if (u_ier[IER_THR_BIT] && u_lsr[LSR_TEMT_BIT])
            return IIR_THR_EMPTY;
        return IIR_NONE;
    endfunction

    function automatic bit rx_push(input logic [7:0] b);
        if (rx_level >= DEPTH)
            return 1'b0;
        rx_mem[(rx_ptr + rx_level) % DEPTH] = b;
        rx_level++;
        u_lsr[LSR_DR_BIT] = 1'b1;
        return 1'b1;
    endfunction

    function automatic uart_rsp_t uart_next_response(input logic [1:0] c, input logic [2:0] off,
                                                     input logic [7:0] d, input logic first);
        uart_rsp_t r;
        logic      dlab;
        r = '0;
        dlab = u_lcr[LCR_DLAB_BIT];
        case (c)
            CMD_HOST_READ: begin
                case (off)
                    OFF_DATA: begin
                        if (dlab) begin
                            r.read_byte = u_dll;
                        end else if (rx_level == 0) begin
                            r.status = 1'b1;
                        end else begin
                            r.read_byte = rx_mem[rx_ptr];
                            rx_ptr = (rx_ptr + 1) % DEPTH;
                            rx_level--;
                            if (rx_level == 0)
                                u_lsr[LSR_DR_BIT] = 1'b0;
                        end
                    end
                    OFF_IER: r.read_byte = dlab ? u_dlm : {4'h0, u_ier};
                    OFF_IIR: r.read_byte = iir_code() | IIR_FIFO_ON;
                    OFF_LCR: r.read_byte = u_lcr;
                    OFF_MCR: r.read_byte = u_mcr;
                    OFF_LSR: r.read_byte = u_lsr;
                    OFF_MSR: r.read_byte = MSR_CONST;
                    default: r.read_byte = u_scr;
                endcase
            end
            CMD_HOST_WRITE: begin
                case (off)
                    OFF_DATA: begin
                        if (dlab) begin
                            u_dll = d;
                        end else if (u_mcr[MCR_LOOP_BIT]) begin
                            if (!rx_push(d))
                                r.status = 1'b1;
                        end else begin
                            if (tx_level < DEPTH) begin
                                tx_mem[(tx_ptr + tx_level) % DEPTH] = d;
                                tx_level++;
                                u_lsr[LSR_TEMT_BIT] = 1'b0;
                            end else begin
                                r.status = 1'b1;
                            end
                            if (tx_level >= DEPTH / 2)
                                u_lsr[LSR_THRE_BIT] = 1'b0;
                        end
                    end
                    OFF_IER: begin
                        if (dlab)
                            u_dlm = d;
                        else
                            u_ier = d[3:0] & IER_MASK;
                    end
                    OFF_IIR: begin
                        // FIFO clear bits act once and never stick in FCR
                        u_fcr = d;
                        u_fcr[FCR_CLR_RX_BIT] = 1'b0;
                        u_fcr[FCR_CLR_TX_BIT] = 1'b0;
                        if (d[FCR_CLR_RX_BIT]) begin
                            rx_level = 0;
                            rx_ptr = 0;
                            u_lsr[LSR_DR_BIT] = 1'b0;
                            rx_burst = 1'b0;
                        end
                        if (d[FCR_CLR_TX_BIT]) begin
                            tx_level = 0;
                            tx_ptr = 0;
                            u_lsr[LSR_TEMT_BIT] = 1'b1;
                            u_lsr[LSR_THRE_BIT] = 1'b1;
                        end
                    end
                    OFF_LCR: u_lcr = d;
                    OFF_MCR: u_mcr = d;
                    OFF_SCR: u_scr = d;
                    default: ;
                endcase
            end
            CMD_LINE_RX: begin
                if (first) begin
                    rx_burst = 1'b0;
                    if (u_mcr[MCR_LOOP_BIT] || u_lsr[LSR_DR_BIT] || rx_level > 0)
                        r.status = 1'b1;
                    else
                        rx_burst = 1'b1;
                end else if (!rx_burst) begin
                    r.status = 1'b1;
                end
                if (!r.status && !rx_push(d)) begin
                    r.status = 1'b1;
                    rx_burst = 1'b0;
                end
            end
            default: begin
                if (tx_level == 0) begin
                    r.status = 1'b1;
                end else begin
                    r.read_byte = tx_mem[tx_ptr];
                    tx_ptr = (tx_ptr + 1) % DEPTH;
                    tx_level--;
                    if (tx_level == 0) begin
                        u_lsr[LSR_TEMT_BIT] = 1'b1;
                        u_lsr[LSR_THRE_BIT] = 1'b1;
                    end
                end
            end
        endcase
        r.irq_level = (iir_code() != IIR_NONE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitors: predict on command transactions, check on responses
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    always @(posedge clk) begin
        uart_rsp_t predicted;
        if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
            predicted = uart_next_response(cmd_ch.command, cmd_ch.reg_offset,
                                           cmd_ch.data_byte, cmd_ch.burst_start);
            if (cur_row.typed)
                pending_responses.push_back({cur_row.want_byte, cur_row.want_status,
                                             cur_row.want_irq});
            else
                pending_responses.push_back(predicted);
        end
    end

    always @(posedge clk) begin
        uart_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
                flag_mismatch($sformatf("response %0d with nothing pending: rd=%02h st=%0b irq=%0b",
                                        responses_seen, rsp_ch.read_byte, rsp_ch.status,
                                        rsp_ch.irq_level));
            end else begin
                want = pending_responses.pop_front();
                if (rsp_ch.read_byte !== want.read_byte || rsp_ch.status !== want.status ||
                    rsp_ch.irq_level !== want.irq_level)
                    flag_mismatch($sformatf(
                        "response %0d: expected rd=%02h st=%0b irq=%0b, got rd=%02h st=%0b irq=%0b",
                        responses_seen, want.read_byte, want.status, want.irq_level,
                        rsp_ch.read_byte, rsp_ch.status, rsp_ch.irq_level));
            end
        end
    end

    // ------------------------------------------------------------------
    // Response side: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : rsp_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, snk_gap_max);
            if (rsp_hold_cycles > 0) begin
                stall = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_item(input stim_row_t row);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_row = row;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= row.command;
        cmd_ch.reg_offset  <= row.reg_offset;
        cmd_ch.data_byte   <= row.data_byte;
        cmd_ch.burst_start <= row.burst_start;
        do @(posedge clk); while (!cmd_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send(input logic [1:0] c, input logic [2:0] off, input logic [7:0] d,
                        input logic first);
        stim_row_t row;
        row = '0;
        row.command = c;
        row.reg_offset = off;
        row.data_byte = d;
        row.burst_start = first;
        send_item(row);
    endtask

    // Drop valid and hold until every pending response is back
    task automatic wait_all_answered();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_responses.size() > 0)
            @(negedge clk);
    endtask

    // Bring DLAB off and loopback to the wanted setting
    task automatic set_data_path(input bit want_loop);
        logic [7:0] v;
        if (u_lcr[LCR_DLAB_BIT])
            send(CMD_HOST_WRITE, OFF_LCR, {1'b0, 7'($urandom)}, 1'($urandom));
        if (u_mcr[MCR_LOOP_BIT] != want_loop) begin
            v = 8'($urandom);
            v[MCR_LOOP_BIT] = want_loop;
            send(CMD_HOST_WRITE, OFF_MCR, v, 1'($urandom));
        end
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 15;
        endcase
    endfunction

    task automatic run_directed();
        stim_row_t rows [27];
        rows = '{
            '{CMD_HOST_READ,  OFF_LSR,  8'h00, 1'b0, 1'b1, 8'h60, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_MCR,  8'h00, 1'b0, 1'b1, MCR_RESET, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_MSR,  8'h00, 1'b0, 1'b1, MSR_CONST, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_IIR,  8'h00, 1'b0, 1'b1, IIR_FIFO_ON | IIR_NONE, 1'b0, 1'b0},
            // empty RX read, empty TX pull, stray line byte: all refused
            '{CMD_HOST_READ,  OFF_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
            '{CMD_LINE_TX,    OFF_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
            '{CMD_LINE_RX,    OFF_DATA, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
            // divisor latches under DLAB
            '{CMD_HOST_WRITE, OFF_LCR,  8'h80, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_DATA, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_IER,  8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_DATA, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_IER,  8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_LCR,  8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_IER,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // read-only LSR and MSR ignore writes; then a scratch write
            '{CMD_HOST_WRITE, OFF_LSR,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_MSR,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_SCR,  8'hA5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // burst of two, then a restart refused while RX holds data
            '{CMD_LINE_RX,    OFF_DATA, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_LINE_RX,    OFF_SCR,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_LINE_RX,    OFF_DATA, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_DATA, 8'h81, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_LINE_TX,    OFF_SCR,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_IIR,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // loopback: THR write lands in RX
            '{CMD_HOST_WRITE, OFF_MCR,  8'h18, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_WRITE, OFF_DATA, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{CMD_HOST_READ,  OFF_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
        };
        foreach (rows[i])
            send_item(rows[i]);
    endtask

    task automatic run_random_traffic();
        int  kind;
        int  n;
        bit  hold_done;
        bit  pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        while (items_sent < 27 + RANDOM_ITEMS) begin
            src_gap_max = pick_gap();
            snk_gap_max = pick_gap();
            // back-pressure: stall responses while commands keep coming
            if (!hold_done && items_sent >= 400) begin
                hold_done = 1'b1;
                src_gap_max = 0;
                rsp_hold_cycles = 300;
            end
            if (!pause_done && items_sent >= 800) begin
                pause_done = 1'b1;
                wait_all_answered();
            end
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                // fill TX, sometimes past full, then drain some or all of it
                set_data_path(1'b0);
                n = $urandom_range(1, DEPTH + 3);
                repeat (n) begin
                    send(CMD_HOST_WRITE, OFF_DATA, 8'($urandom), 1'($urandom));
                    if ($urandom_range(0, 3) == 0)
                        send(CMD_HOST_READ, OFF_LSR, 8'($urandom), 1'($urandom));
                end
                repeat ($urandom_range(0, n + 2))
                    send(CMD_LINE_TX, 3'($urandom), 8'($urandom), 1'($urandom));
            end else if (kind < 50) begin
                // received burst, then host reads
                set_data_path(1'b0);
                if ($urandom_range(0, 1))
                    while (rx_level > 0)
                        send(CMD_HOST_READ, OFF_DATA, 8'($urandom), 1'($urandom));
                n = $urandom_range(1, DEPTH + 3);
                send(CMD_LINE_RX, 3'($urandom), 8'($urandom), 1'b1);
                repeat (n - 1)
                    send(CMD_LINE_RX, 3'($urandom), 8'($urandom), $urandom_range(0, 9) == 0);
                repeat ($urandom_range(0, n + 2)) begin
                    if ($urandom_range(0, 4) == 0)
                        send(CMD_HOST_READ, 3'($urandom_range(OFF_IER, OFF_LSR)),
                             8'($urandom), 1'($urandom));
                    else
                        send(CMD_HOST_READ, OFF_DATA, 8'($urandom), 1'($urandom));
                end
            end else if (kind < 62) begin
                // loopback traffic, with a refused line burst now and then
                set_data_path(1'b1);
                n = $urandom_range(1, DEPTH + 2);
                repeat (n)
                    send(CMD_HOST_WRITE, OFF_DATA, 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 2) == 0)
                    send(CMD_LINE_RX, 3'($urandom), 8'($urandom), 1'b1);
                repeat ($urandom_range(0, n + 1))
                    send(CMD_HOST_READ, OFF_DATA, 8'($urandom), 1'($urandom));
            end else if (kind < 72) begin
                // divisor latch access
                send(CMD_HOST_WRITE, OFF_LCR, 8'($urandom) | 8'h80, 1'($urandom));
                send(CMD_HOST_WRITE, OFF_DATA, 8'($urandom), 1'($urandom));
                send(CMD_HOST_WRITE, OFF_IER, 8'($urandom), 1'($urandom));
                send(CMD_HOST_READ, OFF_DATA, 8'($urandom), 1'($urandom));
                send(CMD_HOST_READ, OFF_IER, 8'($urandom), 1'($urandom));
                send(CMD_HOST_READ, OFF_LCR, 8'($urandom), 1'($urandom));
                send(CMD_HOST_WRITE, OFF_LCR, 8'($urandom) & 8'h7F, 1'($urandom));
            end else if (kind < 80) begin
                send(CMD_HOST_WRITE, OFF_IER, 8'($urandom), 1'($urandom));
                send(CMD_HOST_WRITE, OFF_IIR, 8'($urandom), 1'($urandom));
                send(CMD_HOST_WRITE, OFF_SCR, 8'($urandom), 1'($urandom));
                for (int o = OFF_IER; o <= OFF_SCR; o++)
                    send(CMD_HOST_READ, 3'(o), 8'($urandom), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    send(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_HOST_READ;
        cmd_ch.reg_offset = OFF_DATA;
        cmd_ch.data_byte = 8'h00;
        cmd_ch.burst_start = 1'b0;
        cur_row = '0;
        u_lcr = 8'h00;
        u_ier = 4'h0;
        u_mcr = MCR_RESET;
        u_fcr = 8'h00;
        u_scr = 8'h00;
        u_dll = 8'h00;
        u_dlm = 8'h00;
        u_lsr = 8'h60;
        rx_level = 0;
        tx_level = 0;
        rx_ptr = 0;
        tx_ptr = 0;
        rx_burst = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random_traffic();

        wait_all_answered();
        repeat (8) @(negedge clk);
        if (pending_responses.size() > 0)
            flag_mismatch($sformatf("%0d responses never arrived", pending_responses.size()));

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== uart_16550a_register_model_core.f =====
hdl/u16550_pkg.sv
hdl/u16550_if.sv
hdl/u16550_fifo.sv
hdl/uart_16550a_register_model_core.sv
tb/sv/uart_16550a_register_model_core_tb.sv
